### design/cfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfe_pkg
// Shared constants, types and helpers of the COBS frame encoder.
// ----------------------------------------------------------------------------
package cfe_pkg;

  localparam int OUT_DEPTH = 4096;
  localparam int PTR_W     = $clog2(OUT_DEPTH + 1);
  localparam int ADDR_W    = 12;
  localparam int DATA_W    = 8;
  localparam int LEN_W     = 13;
  localparam int Q_DEPTH   = 4;
  localparam int Q_AW      = $clog2(Q_DEPTH);
  localparam int NSLOT     = 4;

  localparam logic [DATA_W-1:0] CODE_MAX  = 8'hff;
  localparam logic [DATA_W-1:0] CODE_INIT = 8'h01;
  localparam logic [DATA_W-1:0] DELIM     = 8'h00;

  // write slots of one item, in emission order
  localparam int SLOT_DATA  = 0;
  localparam int SLOT_BLOCK = 1;
  localparam int SLOT_FINAL = 2;
  localparam int SLOT_DELIM = 3;

  typedef struct packed {
    logic [PTR_W-1:0]  addr;
    logic [DATA_W-1:0] data;
    logic              ovf;
  } cfe_wr_t;

  typedef struct packed {
    logic [NSLOT-1:0]  vld;
    cfe_wr_t [NSLOT-1:0] wr;
    logic [LEN_W-1:0]  len;
  } cfe_rec_t;

  typedef struct packed {
    logic     valid;
    cfe_rec_t rec;
  } cfe_head_t;

  // pointer advance, saturating at the memory size
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p < PTR_W'(OUT_DEPTH)) ? p + PTR_W'(1) : p;
  endfunction

  function automatic logic ptr_drop(input logic [PTR_W-1:0] p);
    ptr_drop = (p >= PTR_W'(OUT_DEPTH));
  endfunction

endpackage

### design/cfe_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfe_in_if / cfe_out_if
// Valid/ready channels for payload bytes in and memory writes out.
// ----------------------------------------------------------------------------
interface cfe_in_if import cfe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              has_byte;
  logic              frame_end;

  modport source (output valid, output data_byte, output has_byte, output frame_end,
                  input ready);
  modport sink   (input valid, input data_byte, input has_byte, input frame_end,
                  output ready);
endinterface

interface cfe_out_if import cfe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] write_addr;
  logic [DATA_W-1:0] write_data;
  logic              frame_done;
  logic [LEN_W-1:0]  frame_length;
  logic              overflow;
  logic              run_last;

  modport source (output valid, output write_addr, output write_data, output frame_done,
                  output frame_length, output overflow, output run_last, input ready);
  modport sink   (input valid, input write_addr, input write_data, input frame_done,
                  input frame_length, input overflow, input run_last, output ready);
endinterface

### design/cfe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfe_front
// Accepts payload items, tracks the encoder pointers and turns each item
// into a record of up to four candidate memory writes.
// ----------------------------------------------------------------------------
module cfe_front import cfe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  cfe_in_if.sink    in_ch,
  input  logic      q_full,
  output logic      push,
  output cfe_rec_t  push_rec
);

  logic [DATA_W-1:0] cv_r, cv_nxt;
  logic [PTR_W-1:0]  wp_r, wp_nxt;
  logic [PTR_W-1:0]  cp_r, cp_nxt;
  logic              ovs_r, ovs_nxt;
  logic              accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  always_comb begin
    logic              byte_nz;
    logic              has_a, has_b, has_c, has_d;
    logic [DATA_W-1:0] cv1, cv2;
    logic [PTR_W-1:0]  wp1, wp2, cp2;
    logic              drop_a, drop_b, drop_c, drop_d;
    logic              item_drop;

    byte_nz = (in_ch.data_byte != DELIM);
    has_a   = in_ch.has_byte && byte_nz;
    wp1     = has_a ? ptr_inc(wp_r) : wp_r;
    cv1     = has_a ? cv_r + DATA_W'(1) : cv_r;

    // block closes on a zero byte or when it holds 254 data bytes
    has_b = in_ch.has_byte && (!byte_nz || cv1 == CODE_MAX);
    cv2   = has_b ? CODE_INIT : cv1;
    cp2   = has_b ? wp1 : cp_r;
    wp2   = (has_b && (!byte_nz || !in_ch.frame_end)) ? ptr_inc(wp1) : wp1;

    // final code is skipped when it would land on the delimiter
    has_c = in_ch.frame_end && (cp2 != wp2);
    has_d = in_ch.frame_end;

    drop_a = ptr_drop(wp_r);
    drop_b = ptr_drop(cp_r);
    drop_c = ptr_drop(cp2);
    drop_d = ptr_drop(wp2);
    item_drop = (has_a && drop_a) || (has_b && drop_b) || (has_c && drop_c)
                || (has_d && drop_d);

    push_rec.vld = {has_d, has_c, has_b, has_a};
    push_rec.wr[SLOT_DATA]  = '{addr: wp_r, data: in_ch.data_byte, ovf: drop_a};
    push_rec.wr[SLOT_BLOCK] = '{addr: cp_r, data: cv1, ovf: drop_b};
    push_rec.wr[SLOT_FINAL] = '{addr: cp2, data: cv2, ovf: drop_c};
    push_rec.wr[SLOT_DELIM] = '{addr: wp2, data: DELIM, ovf: drop_d || ovs_r || item_drop};
    push_rec.len = LEN_W'(ptr_inc(wp2));

    push = accept && (has_a || has_b || has_d);

    if (in_ch.frame_end) begin
      cv_nxt  = CODE_INIT;
      wp_nxt  = PTR_W'(1);
      cp_nxt  = '0;
      ovs_nxt = 1'b0;
    end else begin
      cv_nxt  = cv2;
      wp_nxt  = wp2;
      cp_nxt  = cp2;
      ovs_nxt = ovs_r || item_drop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r  <= CODE_INIT;
      wp_r  <= PTR_W'(1);
      cp_r  <= '0;
      ovs_r <= 1'b0;
    end else if (accept) begin
      cv_r  <= cv_nxt;
      wp_r  <= wp_nxt;
      cp_r  <= cp_nxt;
      ovs_r <= ovs_nxt;
    end
  end

endmodule

### design/cfe_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfe_queue
// Short FIFO of write records between the front and the back end.
// ----------------------------------------------------------------------------
module cfe_queue import cfe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cfe_rec_t  push_rec,
  input  logic      pop,
  output logic      full,
  output cfe_head_t head
);

  cfe_rec_t        mem [Q_DEPTH];
  logic [Q_AW-1:0] rd_r, rd_nxt;
  logic [Q_AW-1:0] wr_r, wr_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full       = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.rec   = mem[rd_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head.valid;

  always_comb begin
    rd_nxt  = do_pop  ? rd_r + Q_AW'(1) : rd_r;
    wr_nxt  = do_push ? wr_r + Q_AW'(1) : wr_r;
    cnt_nxt = cnt_r + (Q_AW+1)'(do_push) - (Q_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= '0;
      wr_r  <= '0;
      cnt_r <= '0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### design/cfe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfe_back
// Walks the valid writes of the head record, one per cycle while the output is ready,
// into the registered output channel.
// ----------------------------------------------------------------------------
module cfe_back import cfe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfe_head_t head,
  output logic      pop,
  cfe_out_if.source out_ch
);

  logic [NSLOT-1:0]  sent_r, sent_nxt;
  logic              vld_r, vld_nxt;
  logic [ADDR_W-1:0] addr_r;
  logic [DATA_W-1:0] data_r;
  logic              done_r;
  logic [LEN_W-1:0]  len_r;
  logic              ovf_r;
  logic              last_r;
  logic [NSLOT-1:0]  rem;
  logic [NSLOT-1:0]  sel;
  logic              last;
  logic              load;
  cfe_wr_t           cur;

  assign rem  = head.rec.vld & ~sent_r;
  assign sel  = rem & (~rem + NSLOT'(1));   // lowest pending slot
  assign last = ((rem & ~sel) == '0);
  assign load = head.valid && (!vld_r || out_ch.ready);
  assign pop  = load && last;

  always_comb begin
    cur = '0;
    for (int i = 0; i < NSLOT; i++) begin
      if (sel[i]) begin
        cur = head.rec.wr[i];
      end
    end
  end

  always_comb begin
    sent_nxt = sent_r;
    vld_nxt  = vld_r;
    if (load) begin
      sent_nxt = last ? '0 : (sent_r | sel);
      vld_nxt  = 1'b1;
    end else if (out_ch.ready) begin
      vld_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sent_r <= '0;
      vld_r  <= 1'b0;
    end else begin
      sent_r <= sent_nxt;
      vld_r  <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      addr_r <= ADDR_W'(cur.addr);
      data_r <= cur.data;
      done_r <= sel[SLOT_DELIM];
      len_r  <= sel[SLOT_DELIM] ? head.rec.len : '0;
      ovf_r  <= cur.ovf;
      last_r <= last;
    end
  end

  assign out_ch.valid        = vld_r;
  assign out_ch.write_addr   = addr_r;
  assign out_ch.write_data   = data_r;
  assign out_ch.frame_done   = done_r;
  assign out_ch.frame_length = len_r;
  assign out_ch.overflow     = ovf_r;
  assign out_ch.run_last     = last_r;

endmodule

### design/cobs_frame_encoder_core.sv
`timescale 1ns / 1ps
// The first write of an item passes through the record queue and then the output
//   register before it is presented on the output channel.
// Throughput: one item per cycle when it causes at most one write and the output is ready;
//   an item causing k writes (k up to 3) holds the single write port until all are sent.
// A 4-entry record queue lets the front keep taking items during such bursts.
// Reset (rst_n low, synchronous) restores the frame pointers and empties the queue
//   and output register.
// ----------------------------------------------------------------------------
// cobs_frame_encoder_core
// Streaming COBS encoder emitting address/data writes into an output memory.
// ----------------------------------------------------------------------------
module cobs_frame_encoder_core import cfe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  cfe_in_if.sink    in_ch,
  cfe_out_if.source out_ch
);

  logic      q_push;
  logic      q_full;
  logic      q_pop;
  cfe_rec_t  q_rec;
  cfe_head_t q_head;

  cfe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (q_push),
    .push_rec (q_rec)
  );

  cfe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (q_rec),
    .pop      (q_pop),
    .full     (q_full),
    .head     (q_head)
  );

  cfe_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (q_head),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

`ifndef SYNTHESIS
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.frame_done |-> out_ch.run_last)
    else $error("delimiter write is not the last write of its item");

  a_len_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.frame_done |-> out_ch.frame_length == '0)
    else $error("frame length outside delimiter write");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("record queue overrun");

  a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head.valid && q_head.rec.vld != '0)
    else $error("pop of empty record");
`endif

endmodule
